// ===== design/mmtm_pkg.sv =====
package mmtm_pkg;

  // sizing
  localparam int AXIS_WIDTH     = 16;
  localparam int COUNT_WIDTH    = 16;
  localparam int BASE_FRAC_BITS = 8;

  localparam int SUM_W   = 2 * AXIS_WIDTH + 2;
  localparam int ROOT_W  = AXIS_WIDTH + 1;
  localparam int REM_W   = ROOT_W + 3;
  localparam int BASE_W  = 16 + BASE_FRAC_BITS;
  localparam int MAGF_W  = ROOT_W + BASE_FRAC_BITS;
  localparam int DEV_W   = ((MAGF_W > BASE_W) ? MAGF_W : BASE_W) + 1;
  localparam int ACC_W   = DEV_W + 8;

  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  // ema weights, 8 fraction bits
  localparam int W_OLD   = 251;
  localparam int W_NEW   = 5;
  localparam int W_SHIFT = 8;
  localparam int ONE_G   = 8192;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(ONE_G) << BASE_FRAC_BITS;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_WINDOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALL_WINDOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME    = 3'd4;

  localparam logic [15:0] RST_MOTION_THRESHOLD = 16'd1229;
  localparam logic [15:0] RST_MOTION_WINDOW    = 16'd3000;
  localparam logic [15:0] RST_HALL_WINDOW      = 16'd3000;
  localparam logic [15:0] RST_DEBOUNCE_TIME    = 16'd50;

  // axis select for the shared squarer
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic        accel_enable;
    logic [15:0] motion_threshold;
    logic [15:0] motion_window;
    logic [15:0] hall_window;
    logic [15:0] debounce_time;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       square;
    logic [1:0] axis_sel;
    logic       root_step;
    logic       check;
    logic       commit;
  } cmd_t;

  function automatic logic [15:0] sat16(logic [31:0] v);
    logic [15:0] r;
    r = (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    return r;
  endfunction

endpackage

// ===== design/mmtm_cfg.sv =====
module mmtm_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mmtm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mmtm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output mmtm_pkg::cfg_t                  cfg_o
);
  import mmtm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ACCEL_ENABLE:     cfg_d.accel_enable     = cfg_data_i[0];
        REG_MOTION_THRESHOLD: cfg_d.motion_threshold = cfg_data_i;
        REG_MOTION_WINDOW:    cfg_d.motion_window    = cfg_data_i;
        REG_HALL_WINDOW:      cfg_d.hall_window      = cfg_data_i;
        REG_DEBOUNCE_TIME:    cfg_d.debounce_time    = cfg_data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_enable     <= 1'b1;
      cfg_q.motion_threshold <= RST_MOTION_THRESHOLD;
      cfg_q.motion_window    <= RST_MOTION_WINDOW;
      cfg_q.hall_window      <= RST_HALL_WINDOW;
      cfg_q.debounce_time    <= RST_DEBOUNCE_TIME;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/mmtm_ctrl.sv =====
module mmtm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  logic           accel_enable_i,
  output mmtm_pkg::cmd_t cmd_o
);
  import mmtm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SQUARE = 5'b00010,
    ST_ROOT   = 5'b00100,
    ST_CHECK  = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              accept;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cmd_o        = '0;
    cmd_o.axis_sel = step_q[1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = accel_enable_i ? ST_SQUARE : ST_COMMIT;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        if (step_q[1:0] == AXIS_Z) begin
          step_d  = '0;
          state_d = ST_ROOT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_CHECK;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !accept && (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/mmtm_dp.sv =====
module mmtm_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mmtm_pkg::cmd_t                        cmd_i,
  input  mmtm_pkg::cfg_t                        cfg_i,
  input  logic [31:0]                           now_ms_i,
  input  logic signed [mmtm_pkg::AXIS_WIDTH-1:0] accel_x_i,
  input  logic signed [mmtm_pkg::AXIS_WIDTH-1:0] accel_y_i,
  input  logic signed [mmtm_pkg::AXIS_WIDTH-1:0] accel_z_i,
  input  logic                                  hall_level_i,
  output logic                                  motion_now_o,
  output logic                                  motion_fresh_o,
  output logic                                  hall_fresh_o,
  output logic [15:0]                           motion_events_o,
  output logic [15:0]                           hall_events_o,
  output logic [15:0]                           magnitude_o,
  output logic [15:0]                           baseline_level_o
);
  import mmtm_pkg::*;

  // captured transaction
  logic [31:0]                  now_q;
  logic signed [AXIS_WIDTH-1:0] ax_q, ay_q, az_q;
  logic                         lvl_q, en_q;

  // square root datapath
  logic [SUM_W-1:0]  sum_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem_q;
  logic              below_q;

  // tracked state
  logic [BASE_W-1:0]      baseline_q, baseline_d;
  logic                   above_q, above_d;
  logic                   mseen_q, mseen_d;
  logic [31:0]            mtime_q, mtime_d;
  logic [COUNT_WIDTH-1:0] mcnt_q, mcnt_d;
  logic                   hlvl_q, hlvl_d;
  logic [31:0]            hsample_q, hsample_d;
  logic                   hseen_q, hseen_d;
  logic [31:0]            hchange_q, hchange_d;
  logic [COUNT_WIDTH-1:0] hcnt_q, hcnt_d;

  // result registers
  logic        mnow_q, mfresh_q, hfresh_q;
  logic [15:0] mev_q, hev_q, mag_q, blev_q;

  logic signed [AXIS_WIDTH-1:0]   sq_op;
  logic signed [2*AXIS_WIDTH-1:0] sq;
  logic [REM_W-1:0]               rem_sh, trial;
  logic                           ge;
  logic [DEV_W-1:0]               magf, base_ext, dev, thr;
  logic [ACC_W-1:0]               acc;
  logic                           mnow, hchanged;
  logic [31:0]                    sample_gap;

  always_comb begin
    case (cmd_i.axis_sel)
      AXIS_X:  sq_op = ax_q;
      AXIS_Y:  sq_op = ay_q;
      AXIS_Z:  sq_op = az_q;
      default: sq_op = ax_q;
    endcase
  end

  assign sq = sq_op * sq_op;

  // one result bit per step, two radicand bits consumed
  assign rem_sh = {rem_q[REM_W-3:0], sum_q[SUM_W-1 -: 2]};
  assign trial  = {2'b00, root_q[ROOT_W-2:0], 2'b01};
  assign ge     = rem_sh >= trial;

  assign magf     = DEV_W'(root_q) << BASE_FRAC_BITS;
  assign base_ext = DEV_W'(baseline_q);
  assign dev      = (magf >= base_ext) ? (magf - base_ext) : (base_ext - magf);
  assign thr      = DEV_W'(cfg_i.motion_threshold) << BASE_FRAC_BITS;

  assign acc = ACC_W'(baseline_q) * ACC_W'(W_OLD) + ACC_W'(magf) * ACC_W'(W_NEW)
             + (ACC_W'(1) << (W_SHIFT - 1));

  assign mnow       = en_q && !below_q;
  assign sample_gap = now_q - hsample_q;
  assign hchanged   = (sample_gap >= 32'(cfg_i.debounce_time)) && (lvl_q != hlvl_q);

  always_comb begin
    baseline_d = baseline_q;
    above_d    = above_q;
    mseen_d    = mseen_q;
    mtime_d    = mtime_q;
    mcnt_d     = mcnt_q;
    if (en_q) begin
      if (below_q) begin
        baseline_d = acc[W_SHIFT +: BASE_W];
        above_d    = 1'b0;
      end else begin
        mseen_d = 1'b1;
        mtime_d = now_q;
        above_d = 1'b1;
        if (!above_q && (mcnt_q != COUNT_MAX)) mcnt_d = mcnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    hlvl_d    = hlvl_q;
    hsample_d = hsample_q;
    hseen_d   = hseen_q;
    hchange_d = hchange_q;
    hcnt_d    = hcnt_q;
    if (sample_gap >= 32'(cfg_i.debounce_time)) begin
      hsample_d = now_q;
      if (hchanged) begin
        hlvl_d    = lvl_q;
        hchange_d = now_q;
        hseen_d   = 1'b1;
        if (hcnt_q != COUNT_MAX) hcnt_d = hcnt_q + 1'b1;
      end
    end
  end

  // payload, square root and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q  <= now_ms_i;
      ax_q   <= accel_x_i;
      ay_q   <= accel_y_i;
      az_q   <= accel_z_i;
      lvl_q  <= hall_level_i;
      en_q   <= cfg_i.accel_enable;
      sum_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
    end
    if (cmd_i.square) sum_q <= sum_q + SUM_W'($unsigned(sq));
    if (cmd_i.root_step) begin
      sum_q  <= {sum_q[SUM_W-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
    if (cmd_i.check) below_q <= dev < thr;
    if (cmd_i.commit) begin
      mnow_q   <= mnow;
      mfresh_q <= mnow || (mseen_q && ((now_q - mtime_q) <= 32'(cfg_i.motion_window)));
      hfresh_q <= hchanged || (hseen_q && ((now_q - hchange_q) <= 32'(cfg_i.hall_window)));
      mev_q    <= sat16(32'(mcnt_d));
      hev_q    <= sat16(32'(hcnt_d));
      mag_q    <= en_q ? sat16(32'(root_q)) : 16'd0;
      blev_q   <= sat16(32'(baseline_d >> BASE_FRAC_BITS));
    end
  end

  // tracked state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= BASE_RESET;
      above_q    <= 1'b0;
      mseen_q    <= 1'b0;
      mtime_q    <= '0;
      mcnt_q     <= '0;
      hlvl_q     <= 1'b1;
      hsample_q  <= '0;
      hseen_q    <= 1'b0;
      hchange_q  <= '0;
      hcnt_q     <= '0;
    end else if (cmd_i.commit) begin
      baseline_q <= baseline_d;
      above_q    <= above_d;
      mseen_q    <= mseen_d;
      mtime_q    <= mtime_d;
      mcnt_q     <= mcnt_d;
      hlvl_q     <= hlvl_d;
      hsample_q  <= hsample_d;
      hseen_q    <= hseen_d;
      hchange_q  <= hchange_d;
      hcnt_q     <= hcnt_d;
    end
  end

  assign motion_now_o     = mnow_q;
  assign motion_fresh_o   = mfresh_q;
  assign hall_fresh_o     = hfresh_q;
  assign motion_events_o  = mev_q;
  assign hall_events_o    = hev_q;
  assign magnitude_o      = mag_q;
  assign baseline_level_o = blev_q;

endmodule

// ===== design/motion_and_magnet_tamper_monitor.sv =====
// channel | direction | handshake              | payload
// in      | sink      | in_valid_i / in_stall_o  | now_ms, accel_x/y/z, hall_level
// out     | source    | out_valid_o / out_stall_i | motion/hall flags, counters, levels
// cfg     | sink      | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// a transaction with the accelerometer enabled goes from accept to the next accept
// through capture, the shared squarer once per axis, AXIS_WIDTH+1 square root steps,
// threshold compare and commit; with it disabled, only capture and commit
// the square root loop is the longest part
// reset (rst_ni, async low) restores registers and tracked state, output empty
// one output register: a new transaction is taken while a result waits, and the
// commit stalls only if the previous result has not been taken
module motion_and_magnet_tamper_monitor (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [31:0]                            now_ms_i,
  input  logic signed [mmtm_pkg::AXIS_WIDTH-1:0] accel_x_i,
  input  logic signed [mmtm_pkg::AXIS_WIDTH-1:0] accel_y_i,
  input  logic signed [mmtm_pkg::AXIS_WIDTH-1:0] accel_z_i,
  input  logic                                   hall_level_i,
  // output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   motion_now_o,
  output logic                                   motion_fresh_o,
  output logic                                   hall_fresh_o,
  output logic [15:0]                            motion_events_o,
  output logic [15:0]                            hall_events_o,
  output logic [15:0]                            magnitude_o,
  output logic [15:0]                            baseline_level_o,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [mmtm_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mmtm_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import mmtm_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // register file, writes are registered
  mmtm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer: capture, square, root, compare, commit
  mmtm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accel_enable_i (cfg.accel_enable),
    .cmd_o          (cmd)
  );

  // squarer, bit-serial square root, ema baseline, hall debounce, result register
  mmtm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .now_ms_i         (now_ms_i),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .hall_level_i     (hall_level_i),
    .motion_now_o     (motion_now_o),
    .motion_fresh_o   (motion_fresh_o),
    .hall_fresh_o     (hall_fresh_o),
    .motion_events_o  (motion_events_o),
    .hall_events_o    (hall_events_o),
    .magnitude_o      (magnitude_o),
    .baseline_level_o (baseline_level_o)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import mmtm_pkg::*;

  // run limits in clock cycles, phase length in ticks
  localparam int LIMIT_CYCLES    = 400000;
  localparam int SETTLE_CYCLES   = 30;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_TICKS     = 212;

  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // one update tick as offered on the input channel
  typedef struct packed {
    logic [31:0]                   now;
    logic signed [AXIS_WIDTH-1:0]  ax;
    logic signed [AXIS_WIDTH-1:0]  ay;
    logic signed [AXIS_WIDTH-1:0]  az;
    logic                          hall;
  } tick_t;

  // one status report as it leaves the output channel
  typedef struct packed {
    logic        motion_now;
    logic        motion_fresh;
    logic        hall_fresh;
    logic [15:0] motion_events;
    logic [15:0] hall_events;
    logic [15:0] magnitude;
    logic [15:0] baseline_level;
  } status_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // input channel drive
  logic  in_valid = 1'b0;
  tick_t cur_tick = '0;
  logic  in_stall;

  // output channel drive and observation
  logic        rx_wait = 1'b0;
  logic        rx_hold = 1'b0;
  logic        out_stall;
  logic        out_valid;
  logic        motion_now, motion_fresh, hall_fresh;
  logic [15:0] motion_events, hall_events, magnitude, baseline_level;

  // configuration port drive
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  assign out_stall = rx_hold | rx_wait;

  motion_and_magnet_tamper_monitor u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .now_ms_i         (cur_tick.now),
    .accel_x_i        (cur_tick.ax),
    .accel_y_i        (cur_tick.ay),
    .accel_z_i        (cur_tick.az),
    .hall_level_i     (cur_tick.hall),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .motion_now_o     (motion_now),
    .motion_fresh_o   (motion_fresh),
    .hall_fresh_o     (hall_fresh),
    .motion_events_o  (motion_events),
    .hall_events_o    (hall_events),
    .magnitude_o      (magnitude),
    .baseline_level_o (baseline_level),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // -------------------------------------------------------------------
  // shadow of the monitor: registers and tracked state
  // -------------------------------------------------------------------
  logic        sh_enable     = 1'b1;
  logic [15:0] sh_threshold  = RST_MOTION_THRESHOLD;
  logic [15:0] sh_motion_hold = RST_MOTION_WINDOW;
  logic [15:0] sh_hall_hold  = RST_HALL_WINDOW;
  logic [15:0] sh_debounce   = RST_DEBOUNCE_TIME;

  logic [BASE_W-1:0]      sh_baseline     = BASE_RESET;
  logic                   sh_above        = 1'b0;
  logic                   sh_motion_seen  = 1'b0;
  logic [31:0]            sh_last_motion  = '0;
  logic [COUNT_WIDTH-1:0] sh_motion_count = '0;
  logic                   sh_hall_level   = 1'b1;
  logic [31:0]            sh_last_sample  = '0;
  logic                   sh_hall_seen    = 1'b0;
  logic [31:0]            sh_last_change  = '0;
  logic [COUNT_WIDTH-1:0] sh_hall_count   = '0;

  // stimulus and scoreboard storage
  tick_t   pending[$];
  status_t status_q[$];

  int  n_errors   = 0;
  int  n_accepted = 0;
  int  n_cycles   = 0;
  bit  quiet      = 1'b0;
  int  in_gap     = 0;
  int  rx_left    = 0;
  logic in_took   = 1'b0;
  logic out_took  = 1'b0;
  logic drv_next_valid;
  status_t mon_want;

  // time and hall level carried from one generated tick to the next
  logic [31:0] t_cursor  = '0;
  logic        hall_cur  = 1'b1;

  // floor square root, one result bit at a time from the top
  function automatic logic [ROOT_W-1:0] floor_root(logic [63:0] v);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] trial;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = r | (ROOT_W'(1) << b);
      if (64'(trial) * 64'(trial) <= v) r = trial;
    end
    return r;
  endfunction

  // register write as the block sees it, values cut to register width
  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      REG_ACCEL_ENABLE:     sh_enable      = val[0];
      REG_MOTION_THRESHOLD: sh_threshold   = val;
      REG_MOTION_WINDOW:    sh_motion_hold = val;
      REG_HALL_WINDOW:      sh_hall_hold   = val;
      REG_DEBOUNCE_TIME:    sh_debounce    = val;
      default: ;
    endcase
  endfunction

  // advance the tracked state by one tick and form the status it reports
  function automatic status_t next_status(tick_t t);
    status_t     s;
    longint      sx, sy, sz;
    logic [63:0] sum, magf, dev, acc, base64;
    logic [ROOT_W-1:0] root;
    logic [31:0] dt;
    s = '0;
    root = '0;

    // motion part, skipped entirely while the accelerometer is off
    if (sh_enable) begin
      sx = longint'($signed(t.ax));
      sy = longint'($signed(t.ay));
      sz = longint'($signed(t.az));
      sum = 64'(sx * sx + sy * sy + sz * sz);
      root = floor_root(sum);
      magf = 64'(root) << BASE_FRAC_BITS;
      base64 = 64'(sh_baseline);
      dev = (magf >= base64) ? magf - base64 : base64 - magf;
      if (dev < (64'(sh_threshold) << BASE_FRAC_BITS)) begin
        // quiet sample: baseline drifts toward it, rounded half up
        acc = base64 * 64'(W_OLD) + magf * 64'(W_NEW) + (64'd1 << (W_SHIFT - 1));
        sh_baseline = BASE_W'(acc >> W_SHIFT);
        sh_above = 1'b0;
      end else begin
        s.motion_now = 1'b1;
        sh_last_motion = t.now;
        sh_motion_seen = 1'b1;
        // count only the rising crossing, saturating
        if (!sh_above && sh_motion_count != COUNT_MAX) sh_motion_count++;
        sh_above = 1'b1;
      end
    end

    // hall part, sampled no faster than the debounce interval
    dt = t.now - sh_last_sample;
    if (dt >= 32'(sh_debounce)) begin
      sh_last_sample = t.now;
      if (t.hall != sh_hall_level) begin
        sh_hall_level = t.hall;
        sh_last_change = t.now;
        sh_hall_seen = 1'b1;
        if (sh_hall_count != COUNT_MAX) sh_hall_count++;
      end
    end

    dt = t.now - sh_last_motion;
    s.motion_fresh = sh_motion_seen && (dt <= 32'(sh_motion_hold));
    dt = t.now - sh_last_change;
    s.hall_fresh = sh_hall_seen && (dt <= 32'(sh_hall_hold));
    s.motion_events = (32'(sh_motion_count) > 32'h0000_FFFF) ? 16'hFFFF : 16'(sh_motion_count);
    s.hall_events = (32'(sh_hall_count) > 32'h0000_FFFF) ? 16'hFFFF : 16'(sh_hall_count);
    s.magnitude = (32'(root) > 32'h0000_FFFF) ? 16'hFFFF : 16'(root);
    s.baseline_level = 16'(sh_baseline >> BASE_FRAC_BITS);
    return s;
  endfunction

  // idle cycles before the next transaction on either side
  function automatic int draw_idle();
    return quiet ? 0 : int'($urandom_range(0, 9));
  endfunction

  // value around a center, spread evenly over +/- span
  function automatic logic [15:0] jitter(int center, int span);
    int v;
    v = center + int'($urandom_range(0, 2 * span)) - span;
    return 16'(v);
  endfunction

  // random tick: mostly a device at rest with sensor noise, then shakes,
  // tilts and raw noise; time mostly creeps forward with some big jumps
  function automatic tick_t gen_tick();
    tick_t t;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 70)      t_cursor = t_cursor + 32'($urandom_range(0, 30));
    else if (r < 88) t_cursor = t_cursor + 32'($urandom_range(30, 4000));
    else if (r < 93) t_cursor = t_cursor + 32'($urandom_range(4000, 70000));
    else if (r < 97) t_cursor = $urandom();
    else             t_cursor = 32'hFFFF_FFFF - 32'($urandom_range(0, 200));
    t.now = t_cursor;

    r = $urandom_range(0, 99);
    if (r < 55) begin
      t.ax = jitter(0, 150);
      t.ay = jitter(0, 150);
      t.az = jitter(($urandom_range(0, 3) == 0) ? -ONE_G : ONE_G, 150);
    end else if (r < 75) begin
      t.ax = jitter(0, 12000);
      t.ay = jitter(0, 12000);
      t.az = jitter(ONE_G, 12000);
    end else if (r < 85) begin
      t.ax = jitter(ONE_G, 400);
      t.ay = jitter(0, 400);
      t.az = jitter(0, 400);
    end else begin
      t.ax = 16'($urandom());
      t.ay = 16'($urandom());
      t.az = 16'($urandom());
    end

    r = $urandom_range(0, 99);
    if (r < 12)      hall_cur = ~hall_cur;
    else if (r < 16) hall_cur = 1'($urandom());
    t.hall = hall_cur;
    return t;
  endfunction

  task automatic add_tick(input logic [31:0] now, input logic [15:0] x, input logic [15:0] y,
                          input logic [15:0] z, input logic hall);
    tick_t t;
    t.now = now;
    t.ax = x;
    t.ay = y;
    t.az = z;
    t.hall = hall;
    pending.push_back(t);
  endtask

  // one register write on the config port, mirrored into the shadow
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    shadow_write(idx, val);
  endtask

  task automatic set_config(input logic [15:0] en, input logic [15:0] thr,
                            input logic [15:0] mhold, input logic [15:0] hhold,
                            input logic [15:0] deb);
    write_reg(REG_ACCEL_ENABLE, en);
    write_reg(REG_MOTION_THRESHOLD, thr);
    write_reg(REG_MOTION_WINDOW, mhold);
    write_reg(REG_HALL_WINDOW, hhold);
    write_reg(REG_DEBOUNCE_TIME, deb);
  endtask

  // wait until every queued transaction went in and every status came out
  task automatic drain();
    while (pending.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) pending.push_back(gen_tick());
    drain();
  endtask

  // -------------------------------------------------------------------
  // input side: handshake sampling and the shadow update on accept
  // -------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_took <= rst_ni && in_valid && !in_stall;
    if (rst_ni && in_valid && !in_stall) begin
      status_q.push_back(next_status(cur_tick));
      n_accepted++;
    end
  end

  // driver: new payload only once the previous transaction was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      drv_next_valid = in_valid && !in_took;
      if (!drv_next_valid) begin
        if (in_gap != 0) begin
          in_gap = in_gap - 1;
        end else if (pending.size() != 0) begin
          cur_tick <= pending.pop_front();
          drv_next_valid = 1'b1;
          in_gap = draw_idle();
        end
      end
      in_valid <= drv_next_valid;
    end
  end

  // -------------------------------------------------------------------
  // output side: random stall after each taken status
  // -------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) rx_left = draw_idle();
      if (rx_left != 0) begin
        rx_wait <= 1'b1;
        rx_left = rx_left - 1;
      end else begin
        rx_wait <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // monitor: every taken status against the oldest expectation
  always @(posedge clk_i) begin
    out_took <= rst_ni && out_valid && !out_stall;
    if (rst_ni && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $display("%0t ns: status transaction with none expected", $time);
        n_errors++;
      end else begin
        mon_want = status_q.pop_front();
        check_field("motion_now", 32'(mon_want.motion_now), 32'(motion_now));
        check_field("motion_fresh", 32'(mon_want.motion_fresh), 32'(motion_fresh));
        check_field("hall_fresh", 32'(mon_want.hall_fresh), 32'(hall_fresh));
        check_field("motion_events", 32'(mon_want.motion_events), 32'(motion_events));
        check_field("hall_events", 32'(mon_want.hall_events), 32'(hall_events));
        check_field("magnitude", 32'(mon_want.magnitude), 32'(magnitude));
        check_field("baseline_level", 32'(mon_want.baseline_level), 32'(baseline_level));
      end
    end
  end

  // long receiver hold-off while the sender keeps offering, fills the block
  initial begin
    while (n_accepted < 300) @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("%0t ns: timeout, %0d status transactions outstanding", $time, status_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------
  // stimulus sequence
  // -------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed ticks under the reset register values
    add_tick(32'd0, 16'h0000, 16'h0000, 16'h2000, 1'b1);   // at rest, early tick
    add_tick(32'd10, 16'h0000, 16'h0000, 16'h2000, 1'b0);  // hall change inside debounce
    add_tick(32'd50, 16'h0000, 16'h0000, 16'h2000, 1'b0);  // first hall sample
    add_tick(32'd51, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);  // largest positive values
    add_tick(32'd52, 16'h8000, 16'h8000, 16'h8000, 1'b0);  // most negative, still above
    add_tick(32'd53, 16'h0000, 16'h0000, 16'h0000, 1'b0);  // zero vector
    add_tick(32'd54, 16'h0000, 16'h0000, 16'h2000, 1'b1);  // back below threshold
    add_tick(32'd120, 16'hE000, 16'h0000, 16'h0000, 1'b1); // gravity on x, hall sample
    add_tick(32'd121, 16'h0000, 16'h1388, 16'h0000, 1'b1); // new rising crossing
    add_tick(32'd3121, 16'h0000, 16'h0000, 16'h2000, 1'b1); // motion hold edge
    add_tick(32'd3122, 16'h0000, 16'h0000, 16'h2000, 1'b0); // just past the hold
    add_tick(32'hFFFF_FFC0, 16'h0000, 16'h0000, 16'h2000, 1'b0);
    add_tick(32'hFFFF_FFF0, 16'h0000, 16'h0000, 16'hE000, 1'b1);
    add_tick(32'h0000_0010, 16'h8000, 16'h0000, 16'h0000, 1'b1); // time wrapped
    add_tick(32'h0000_0011, 16'h7FFF, 16'hFFFF, 16'h0001, 1'b1);
    add_tick(32'h0000_0012, 16'h0000, 16'h0000, 16'h2000, 1'b0);
    add_tick(32'hA5A5_5A5A, 16'h5555, 16'hAAAA, 16'h0F0F, 1'b1);
    add_tick(32'h5A5A_A5A5, 16'hAAAA, 16'h5555, 16'hF0F0, 1'b0);
    drain();
    t_cursor = 32'h0000_0100;

    // reset values written back, plus writes to unused indexes
    set_config(16'h0001, RST_MOTION_THRESHOLD, RST_MOTION_WINDOW,
               RST_HALL_WINDOW, RST_DEBOUNCE_TIME);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    run_phase(PHASE_TICKS);

    // zero threshold and zero windows, no idling on either side
    quiet = 1'b1;
    set_config(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_phase(PHASE_TICKS);

    // every register at its top value
    quiet = 1'b0;
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(PHASE_TICKS);

    // accelerometer off, upper data bits set
    set_config(16'hFFFE, 16'($urandom_range(0, 3000)), 16'($urandom()),
               16'($urandom_range(0, 5000)), 16'($urandom_range(0, 100)));
    run_phase(PHASE_TICKS);

    // sensitive threshold, short windows
    quiet = 1'b1;
    set_config(16'h0003, 16'($urandom_range(0, 400)), 16'($urandom_range(0, 500)),
               16'($urandom_range(0, 500)), 16'($urandom_range(0, 200)));
    run_phase(PHASE_TICKS);

    // fully random settings
    quiet = 1'b0;
    set_config(16'($urandom()), 16'($urandom()), 16'($urandom()),
               16'($urandom()), 16'($urandom()));
    run_phase(PHASE_TICKS);

    quiet = 1'b1;
    set_config(16'($urandom()), 16'($urandom_range(0, 4000)), 16'($urandom()),
               16'($urandom()), 16'($urandom_range(0, 300)));
    run_phase(PHASE_TICKS);

    // realistic settings to finish
    quiet = 1'b0;
    set_config(16'h0001, 16'($urandom_range(200, 3000)), 16'($urandom_range(0, 5000)),
               16'($urandom_range(0, 5000)), 16'($urandom_range(0, 100)));
    run_phase(PHASE_TICKS);

    if (n_errors == 0 && status_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mmtm_pkg.sv
design/mmtm_cfg.sv
design/mmtm_ctrl.sv
design/mmtm_dp.sv
design/motion_and_magnet_tamper_monitor.sv
sim/tb_top.sv
